/* rtl/core/bf2_pkg.sv */
// bf2_pkg: shared constants and types for the 2x2 box-filter downsampler.
// No dependencies; used by bf2_counter and box_filter_2x2_downsample.
package bf2_pkg;

    localparam int MAX_WIDTH      = 4096;
    localparam int MAX_COMPONENTS = 4;
    localparam int STORE_DEPTH    = (MAX_WIDTH / 2) * MAX_COMPONENTS;

    localparam int CFG_W   = 13;                      // widest register
    localparam int BPP_W   = 3;
    localparam int CNT_W   = $clog2(MAX_WIDTH);       // column / row counter
    localparam int COMP_W  = (MAX_COMPONENTS > 1) ? $clog2(MAX_COMPONENTS) : 1;
    localparam int ADDR_W  = $clog2(STORE_DEPTH);
    localparam int BYTE_W  = 8;
    localparam int PAIR_W  = BYTE_W + 1;
    localparam int IDX_W   = 2;

    // register indexes
    localparam logic [IDX_W-1:0] CFG_IMAGE_WIDTH     = 2'd0;
    localparam logic [IDX_W-1:0] CFG_IMAGE_HEIGHT    = 2'd1;
    localparam logic [IDX_W-1:0] CFG_BYTES_PER_PIXEL = 2'd2;

    localparam logic [CFG_W-1:0] DIM_MIN   = CFG_W'(2);
    localparam logic [CFG_W-1:0] DIM_MAX   = CFG_W'(MAX_WIDTH);
    localparam logic [CFG_W-1:0] DIM_RESET = CFG_W'(256);
    localparam logic [BPP_W-1:0] BPP_MIN   = BPP_W'(1);
    localparam logic [BPP_W-1:0] BPP_MAX   = BPP_W'(MAX_COMPONENTS);
    localparam logic [BPP_W-1:0] BPP_RESET = BPP_W'(4);

    // position of the current item, from the counter block to the datapath
    typedef struct packed {
        logic              in_image;   // inside the even-sized part of the image
        logic              odd_col;
        logic              odd_row;
        logic              last;       // final byte of the downsampled image
        logic [COMP_W-1:0] comp;
        logic [ADDR_W-1:0] slot;       // line store address
    } bf2_pos_t;

endpackage

/* rtl/core/box_filter_2x2_downsample.sv */
// box_filter_2x2_downsample: top level of the 2x2 box-filter downsampler.
// Depends on bf2_pkg, bf2_counter and bf2_ram.
//
//  channel   | ports                          | payload
//  ----------+--------------------------------+-------------------------------
//  in stream | s_tvalid s_tready s_tdata      | [7:0] pixel_byte
//  out stream| m_tvalid m_tready m_tdata m_tlast | [7:0] averaged_byte,
//            |                                |   tlast = last_of_image
//  config    | cfg_we cfg_index cfg_wdata     | 0 width, 1 height, 2 bytes/pixel
//
// One item is accepted per clock while s_tready is high. A result reaches
// m_tvalid once the item that completes its 2x2 block has passed the registered
// read of the 8192 x 9 line store and then the final add in the output
// register. Reset clears counters and handshake state and loads the config
// registers with their defaults; the line store, the data registers and the
// left-pixel holds need no clearing. A stall on m_tready holds the output
// register and the stage behind it; s_tready drops only while both are full.
module box_filter_2x2_downsample (
    input  logic                          clk,
    input  logic                          rst_n,
    // configuration write port
    input  logic                          cfg_we,
    input  logic [bf2_pkg::IDX_W-1:0]     cfg_index,
    input  logic [bf2_pkg::CFG_W-1:0]     cfg_wdata,
    // input stream
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [7:0]                    s_tdata,   // [7:0] pixel_byte
    // output stream
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [7:0]                    m_tdata,   // [7:0] averaged_byte
    output logic                          m_tlast    // last_of_image
);

    bf2_pkg::bf2_pos_t pos;

    logic accept;
    logic produce;      // current item completes a block
    logic s1_adv;

    // left byte of each horizontal pair, one per component
    logic [bf2_pkg::BYTE_W-1:0] left_hold_reg [bf2_pkg::MAX_COMPONENTS];
    logic [bf2_pkg::BYTE_W-1:0] left_sel;

    // line store
    logic                        ram_we, ram_re;
    logic [bf2_pkg::PAIR_W-1:0]  ram_wdata, ram_rdata;

    // stage 1: waiting for the line store read
    logic                        s1_valid_reg, s1_valid_next;
    logic [bf2_pkg::BYTE_W-1:0]  s1_byte_reg, s1_left_reg;
    logic                        s1_last_reg;

    // output register
    logic                        out_valid_reg, out_valid_next;
    logic [bf2_pkg::BYTE_W-1:0]  out_data_reg;
    logic                        out_last_reg;
    logic [bf2_pkg::PAIR_W:0]    sum4;

    assign s1_adv   = s1_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !s1_valid_reg || s1_adv;
    assign accept   = s_tvalid && s_tready;
    assign produce  = pos.in_image && pos.odd_col && pos.odd_row;

    bf2_counter u_counter (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .advance   (accept),
        .pos       (pos)
    );

    assign left_sel = left_hold_reg[pos.comp];

    always_ff @(posedge clk)
    begin
        if (accept && pos.in_image && !pos.odd_col)
            left_hold_reg[pos.comp] <= s_tdata;
    end

    // even rows store the pair sum, odd rows read it back
    assign ram_we    = accept && pos.in_image && pos.odd_col && !pos.odd_row;
    assign ram_re    = accept && produce;
    assign ram_wdata = bf2_pkg::PAIR_W'(left_sel) + bf2_pkg::PAIR_W'(s_tdata);

    bf2_ram #(
        .DEPTH (bf2_pkg::STORE_DEPTH),
        .WIDTH (bf2_pkg::PAIR_W)
    ) u_line_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (pos.slot),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (pos.slot),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (ram_re)
            s1_valid_next = 1'b1;
        else if (s1_adv)
            s1_valid_next = 1'b0;
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (s1_adv)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ram_re)
        begin
            s1_byte_reg <= s_tdata;
            s1_left_reg <= left_sel;
            s1_last_reg <= pos.last;
        end
    end

    // upper pair + lower pair, truncated mean of four
    assign sum4 = (bf2_pkg::PAIR_W+1)'(ram_rdata) + (bf2_pkg::PAIR_W+1)'(s1_left_reg) +
                  (bf2_pkg::PAIR_W+1)'(s1_byte_reg);

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            out_data_reg <= sum4[bf2_pkg::PAIR_W:2];
            out_last_reg <= s1_last_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

    // line store is never written and read by the same item
    a_no_rw_same_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        !(ram_we && ram_re))
        else $error("line store written and read in one cycle");

    // a waiting stage 1 keeps its read data
    a_rdata_held: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_adv) |=> $stable(ram_rdata))
        else $error("line store read data changed under a stalled stage");

    // a moved stage 1 lands in the output register
    a_s1_to_out: assert property (@(posedge clk) disable iff (!rst_n)
        s1_adv |=> m_tvalid)
        else $error("stage 1 advanced but no result presented");

    // a completing item always finds stage 1 free
    a_s1_free: assert property (@(posedge clk) disable iff (!rst_n)
        ram_re |-> (!s1_valid_reg || s1_adv))
        else $error("stage 1 overwritten");

endmodule

/* rtl/core/bf2_counter.sv */
// bf2_counter: configuration registers, component/column/row counters and
// line store address. Depends on bf2_pkg.
module bf2_counter (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [bf2_pkg::IDX_W-1:0]     cfg_index,
    input  logic [bf2_pkg::CFG_W-1:0]     cfg_wdata,
    input  logic                          advance,
    output bf2_pkg::bf2_pos_t             pos
);

    logic [bf2_pkg::CFG_W-1:0]  width_reg;
    logic [bf2_pkg::CFG_W-1:0]  height_reg;
    logic [bf2_pkg::BPP_W-1:0]  bpp_reg;
    logic [bf2_pkg::CNT_W-1:0]  col_reg, col_next;
    logic [bf2_pkg::CNT_W-1:0]  row_reg, row_next;
    logic [bf2_pkg::COMP_W-1:0] comp_reg, comp_next;

    logic [bf2_pkg::CFG_W-1:0]  w, h, even_w, even_h, col_x, row_x;
    logic [bf2_pkg::BPP_W-1:0]  comps, comp_x;
    logic [bf2_pkg::ADDR_W-1:0] pair_x;
    logic [bf2_pkg::ADDR_W-1:0] base;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= bf2_pkg::DIM_RESET;
            height_reg <= bf2_pkg::DIM_RESET;
            bpp_reg    <= bf2_pkg::BPP_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                bf2_pkg::CFG_IMAGE_WIDTH:     width_reg  <= cfg_wdata;
                bf2_pkg::CFG_IMAGE_HEIGHT:    height_reg <= cfg_wdata;
                bf2_pkg::CFG_BYTES_PER_PIXEL: bpp_reg    <= cfg_wdata[bf2_pkg::BPP_W-1:0];
                default: ;
            endcase
        end
    end

    // saturate registers into their legal ranges
    always_comb
    begin
        w = (width_reg < bf2_pkg::DIM_MIN) ? bf2_pkg::DIM_MIN :
            (width_reg > bf2_pkg::DIM_MAX) ? bf2_pkg::DIM_MAX : width_reg;
        h = (height_reg < bf2_pkg::DIM_MIN) ? bf2_pkg::DIM_MIN :
            (height_reg > bf2_pkg::DIM_MAX) ? bf2_pkg::DIM_MAX : height_reg;
        comps = (bpp_reg < bf2_pkg::BPP_MIN) ? bf2_pkg::BPP_MIN :
                (bpp_reg > bf2_pkg::BPP_MAX) ? bf2_pkg::BPP_MAX : bpp_reg;
        even_w = {w[bf2_pkg::CFG_W-1:1], 1'b0};
        even_h = {h[bf2_pkg::CFG_W-1:1], 1'b0};
        col_x  = bf2_pkg::CFG_W'(col_reg);
        row_x  = bf2_pkg::CFG_W'(row_reg);
        comp_x = bf2_pkg::BPP_W'(comp_reg);
    end

    // slot = (col/2) * comps + comp, comps is 1..4: shift-and-add
    always_comb
    begin
        pair_x = bf2_pkg::ADDR_W'(col_reg >> 1);
        case (comps)
            3'd1:    base = pair_x;
            3'd2:    base = pair_x << 1;
            3'd3:    base = (pair_x << 1) + pair_x;
            default: base = pair_x << 2;
        endcase
        pos.slot     = base + bf2_pkg::ADDR_W'(comp_reg);
        pos.comp     = comp_reg;
        pos.odd_col  = col_reg[0];
        pos.odd_row  = row_reg[0];
        pos.in_image = (col_x < even_w) && (row_x < even_h);
        pos.last     = (row_x == even_h - 1'b1) && (col_x == even_w - 1'b1) &&
                       (comp_x == comps - 1'b1);
    end

    // counters wrap at or past their last value
    always_comb
    begin
        comp_next = comp_reg;
        col_next  = col_reg;
        row_next  = row_reg;
        if (comp_x >= comps - 1'b1)
        begin
            comp_next = '0;
            if (col_x >= w - 1'b1)
            begin
                col_next = '0;
                if (row_x >= h - 1'b1)
                    row_next = '0;
                else
                    row_next = row_reg + 1'b1;
            end
            else
            begin
                col_next = col_reg + 1'b1;
            end
        end
        else
        begin
            comp_next = comp_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg  <= '0;
            row_reg  <= '0;
            comp_reg <= '0;
        end
        else if (advance)
        begin
            col_reg  <= col_next;
            row_reg  <= row_next;
            comp_reg <= comp_next;
        end
    end

endmodule

/* rtl/core/bf2_ram.sv */
// bf2_ram: simple dual-port RAM, one write and one registered read port.
// No dependencies.
module bf2_ram #(
    parameter int DEPTH = 8192,
    parameter int WIDTH = 9
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
    end

    always_ff @(posedge clk)
    begin
        if (re)
            rdata <= mem[raddr];
    end

endmodule
